// ----- design/pst_pkg.sv -----
// shared types, codes and constants for the pgm stream sequence tracker
package pst_pkg;

  localparam int SEQ_W_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [3:0] OP_ODATA  = 4'd0;
  localparam logic [3:0] OP_RDATA  = 4'd1;
  localparam logic [3:0] OP_SPM    = 4'd2;
  localparam logic [3:0] OP_NAK    = 4'd3;
  localparam logic [3:0] OP_NCF    = 4'd4;
  localparam logic [3:0] OP_NNAK   = 4'd5;
  localparam logic [3:0] OP_ACK    = 4'd6;
  localparam logic [3:0] OP_REJECT = 4'd7;
  localparam logic [3:0] OP_IGNORE = 4'd8;
  localparam logic [3:0] OP_CLEAR  = 4'd9;

  localparam logic [2:0] K_DATA   = 3'd0;
  localparam logic [2:0] K_SPM    = 3'd1;
  localparam logic [2:0] K_NAKS   = 3'd2;
  localparam logic [2:0] K_REJECT = 3'd3;
  localparam logic [2:0] K_IGNORE = 3'd4;
  localparam logic [2:0] K_CLEAR  = 3'd5;
  localparam logic [2:0] K_NOP    = 3'd6;

  localparam logic [1:0] NS_NAK  = 2'd0;
  localparam logic [1:0] NS_NCF  = 2'd1;
  localparam logic [1:0] NS_NNAK = 2'd2;
  localparam logic [1:0] NS_ACK  = 2'd3;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_SYNC   = 3'd1;
  localparam logic [2:0] ST_REPAIR = 3'd2;
  localparam logic [2:0] ST_ERROR  = 3'd3;
  localparam logic [2:0] ST_IGNORE = 3'd4;

  localparam int N_COUNTERS = 13;
  localparam int C_ODATA  = 0;
  localparam int C_RDATA  = 1;
  localparam int C_SPM    = 2;
  localparam int C_SPMERR = 3;
  localparam int C_NCF    = 4;
  localparam int C_ACK    = 5;
  localparam int C_NAK    = 6;
  localparam int C_NNAK   = 7;
  localparam int C_DROP   = 8;
  localparam int C_DUP    = 9;
  localparam int C_SEQERR = 10;
  localparam int C_MISSED = 11;
  localparam int C_FWD    = 12;

  localparam logic [4:0] RB_LAST_SEQ    = 5'd13;
  localparam logic [4:0] RB_LEAD_SEQ    = 5'd14;
  localparam logic [4:0] RB_TRAIL_SEQ   = 5'd15;
  localparam logic [4:0] RB_SPM_SEQ     = 5'd16;
  localparam logic [4:0] RB_MISSED_SEQ  = 5'd17;
  localparam logic [4:0] RB_MISSED_CNT  = 5'd18;
  localparam logic [4:0] RB_ACT_TIME    = 5'd19;
  localparam logic [4:0] RB_ERR_TIME    = 5'd20;

  // config register index, decoded from paddr[2]
  localparam logic REG_NAK_FWD = 1'b0;
  localparam logic REG_RD_SEL  = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic       rdata;
    logic [1:0] nsub;
    logic       syn;
    logic       fin;
    logic       rst;
    logic       afi;
    logic [6:0] count;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

// ----- design/pst_front.sv -----
// front end: classifies one packet summary into a command for the back end
module pst_front
  import pst_pkg::*;
#(
  parameter int SEQ_WIDTH = SEQ_W_DEF
) (
  input  logic [3:0]           op,
  input  logic [31:0]          seq_number,
  input  logic [31:0]          trail_number,
  input  logic [31:0]          lead_number,
  input  logic                 syn_flag,
  input  logic                 fin_flag,
  input  logic                 rst_flag,
  input  logic                 afi_is_ip,
  input  logic [5:0]           extra_naks,
  output cmd_t                 cmd,
  output logic [SEQ_WIDTH-1:0] sqn,
  output logic [SEQ_WIDTH-1:0] trl,
  output logic [SEQ_WIDTH-1:0] led,
  output logic [SEQ_WIDTH-1:0] sqm1
);

  assign sqn  = seq_number[SEQ_WIDTH-1:0];
  assign trl  = trail_number[SEQ_WIDTH-1:0];
  assign led  = lead_number[SEQ_WIDTH-1:0];
  assign sqm1 = sqn - SEQ_WIDTH'(1);

  always_comb begin
    cmd       = '0;
    cmd.syn   = syn_flag;
    cmd.fin   = fin_flag;
    cmd.rst   = rst_flag;
    cmd.afi   = afi_is_ip;
    cmd.count = {1'b0, extra_naks} + 7'd1;
    unique case (op)
      OP_ODATA: cmd.kind = K_DATA;
      OP_RDATA: begin
        cmd.kind  = K_DATA;
        cmd.rdata = 1'b1;
      end
      OP_SPM: cmd.kind = K_SPM;
      OP_NAK: begin
        cmd.kind = K_NAKS;
        cmd.nsub = NS_NAK;
      end
      OP_NCF: begin
        cmd.kind = K_NAKS;
        cmd.nsub = NS_NCF;
      end
      OP_NNAK: begin
        cmd.kind = K_NAKS;
        cmd.nsub = NS_NNAK;
      end
      OP_ACK: begin
        cmd.kind = K_NAKS;
        cmd.nsub = NS_ACK;
      end
      OP_REJECT: cmd.kind = K_REJECT;
      OP_IGNORE: cmd.kind = K_IGNORE;
      OP_CLEAR:  cmd.kind = K_CLEAR;
      default:   cmd.kind = K_NOP;
    endcase
  end

endmodule

// ----- design/pst_queue.sv -----
// small fifo between the front end and the back end
module pst_queue
  import pst_pkg::*;
#(
  parameter int WIDTH = CMD_W,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    wptr_nxt;
  logic [AW-1:0]    rptr_r;
  logic [AW-1:0]    rptr_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             push;
  logic             pop;

  assign in_ready  = cnt_r != CW'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= in_data;
    end
  end

endmodule

// ----- design/pst_back.sv -----
// back end: session state, event counters and the result register
module pst_back
  import pst_pkg::*;
#(
  parameter int SEQ_WIDTH = SEQ_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  cmd_t                 cmd,
  input  logic [SEQ_WIDTH-1:0] sqn,
  input  logic [SEQ_WIDTH-1:0] trl,
  input  logic [SEQ_WIDTH-1:0] led,
  input  logic [SEQ_WIDTH-1:0] sqm1,
  input  logic [63:0]          now,
  input  logic                 nak_fwd_en,
  input  logic [4:0]           rd_sel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic [2:0]           state_after,
  output logic                 seq_error,
  output logic                 duplicate,
  output logic [31:0]          missed,
  output logic                 forward_nak,
  output logic [63:0]          readback
);

  logic [2:0]           state_r, state_nxt;
  logic [SEQ_WIDTH-1:0] last_r, last_nxt;
  logic [SEQ_WIDTH-1:0] lead_r, lead_nxt;
  logic [SEQ_WIDTH-1:0] trail_r, trail_nxt;
  logic [SEQ_WIDTH-1:0] spm_r, spm_nxt;
  logic [SEQ_WIDTH-1:0] lmseq_r, lmseq_nxt;
  logic [SEQ_WIDTH-1:0] lmcnt_r, lmcnt_nxt;
  logic [63:0]          act_time_r, act_time_nxt;
  logic [63:0]          err_time_r, err_time_nxt;
  logic [31:0]          cnt_r [N_COUNTERS];
  logic [31:0]          cnt_nxt [N_COUNTERS];

  logic                 out_valid_r;
  logic                 acc_r, acc_nxt;
  logic                 serr_r, serr_nxt;
  logic                 dup_r, dup_nxt;
  logic [SEQ_WIDTH-1:0] miss_r, miss_nxt;
  logic                 fwd_r, fwd_nxt;

  logic                 fire;
  logic                 is_pkt;
  logic [SEQ_WIDTH-1:0] last_inc;
  logic [SEQ_WIDTH-1:0] gap;
  logic [31:0]          cnt_add;

  assign q_ready  = !out_valid_r || out_ready;
  assign fire     = q_valid && q_ready;
  assign is_pkt   = cmd.kind == K_DATA || cmd.kind == K_SPM || cmd.kind == K_NAKS ||
                    cmd.kind == K_REJECT;
  assign last_inc = last_r + SEQ_WIDTH'(1);
  assign gap      = sqn - last_r;
  assign cnt_add  = 32'(cmd.count);

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    lead_nxt     = lead_r;
    trail_nxt    = trail_r;
    spm_nxt      = spm_r;
    lmseq_nxt    = lmseq_r;
    lmcnt_nxt    = lmcnt_r;
    act_time_nxt = act_time_r;
    err_time_nxt = err_time_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = 1'b0;
    serr_nxt     = 1'b0;
    dup_nxt      = 1'b0;
    miss_nxt     = '0;
    fwd_nxt      = 1'b0;
    if (is_pkt && (cmd.kind == K_REJECT || state_r == ST_IGNORE)) begin
      cnt_nxt[C_DROP] = cnt_r[C_DROP] + 32'd1;
      err_time_nxt    = now;
    end else begin
      unique case (cmd.kind)
        K_IGNORE: state_nxt = ST_IGNORE;
        K_CLEAR: begin
          for (int i = 0; i < N_COUNTERS; i++) begin
            cnt_nxt[i] = '0;
          end
          err_time_nxt = '0;
        end
        K_DATA: begin
          acc_nxt = 1'b1;
          if (state_r == ST_INIT || cmd.syn) begin
            state_nxt = ST_INIT;
            last_nxt  = sqn;
          end else if (cmd.rdata) begin
            cnt_nxt[C_RDATA] = cnt_r[C_RDATA] + 32'd1;
            err_time_nxt     = now;
          end else begin
            cnt_nxt[C_ODATA] = cnt_r[C_ODATA] + 32'd1;
            if (sqn <= last_r) begin
              cnt_nxt[C_DUP] = cnt_r[C_DUP] + 32'd1;
              last_nxt       = sqn;
              err_time_nxt   = now;
              acc_nxt        = 1'b0;
              dup_nxt        = 1'b1;
            end else begin
              if (trl > trail_r) begin
                trail_nxt = trl;
              end
              if (sqn > lead_r) begin
                lead_nxt = sqn;
              end
              if (last_r > SEQ_WIDTH'(1) && sqn != last_inc && !cmd.rst) begin
                miss_nxt            = gap;
                state_nxt           = ST_REPAIR;
                cnt_nxt[C_SEQERR]   = cnt_r[C_SEQERR] + 32'd1;
                cnt_nxt[C_MISSED]   = cnt_r[C_MISSED] + 32'(gap);
                lmseq_nxt           = sqm1;
                lmcnt_nxt           = gap;
                err_time_nxt        = now;
                serr_nxt            = 1'b1;
              end else begin
                act_time_nxt = now;
              end
              last_nxt = sqn;
            end
          end
          if (acc_nxt && cmd.fin) begin
            state_nxt = ST_INIT;
          end
        end
        K_SPM: begin
          acc_nxt        = 1'b1;
          cnt_nxt[C_SPM] = cnt_r[C_SPM] + 32'd1;
          if (!cmd.afi) begin
            cnt_nxt[C_SPMERR] = cnt_r[C_SPMERR] + 32'd1;
          end else if (cmd.rst) begin
            state_nxt = ST_ERROR;
          end else if (cmd.fin) begin
            state_nxt = ST_INIT;
          end else if (spm_r != '0 && state_r == ST_SYNC && sqn <= spm_r) begin
            cnt_nxt[C_SPMERR] = cnt_r[C_SPMERR] + 32'd1;
          end else begin
            state_nxt = ST_SYNC;
            spm_nxt   = sqn;
            trail_nxt = trl;
            lead_nxt  = led;
          end
        end
        K_NAKS: begin
          acc_nxt = 1'b1;
          unique case (cmd.nsub)
            NS_ACK: cnt_nxt[C_ACK] = cnt_r[C_ACK] + cnt_add;
            NS_NAK: begin
              cnt_nxt[C_NAK] = cnt_r[C_NAK] + cnt_add;
              err_time_nxt   = now;
            end
            NS_NCF: begin
              cnt_nxt[C_NCF] = cnt_r[C_NCF] + cnt_add;
              err_time_nxt   = now;
            end
            default: begin
              cnt_nxt[C_NNAK] = cnt_r[C_NNAK] + cnt_add;
              err_time_nxt    = now;
            end
          endcase
          if (cmd.nsub == NS_NAK && state_r == ST_SYNC && nak_fwd_en) begin
            fwd_nxt        = 1'b1;
            cnt_nxt[C_FWD] = cnt_r[C_FWD] + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      last_r      <= '0;
      lead_r      <= '0;
      trail_r     <= '0;
      spm_r       <= '0;
      lmseq_r     <= '0;
      lmcnt_r     <= '0;
      act_time_r  <= '0;
      err_time_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N_COUNTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (fire) begin
        state_r     <= state_nxt;
        last_r      <= last_nxt;
        lead_r      <= lead_nxt;
        trail_r     <= trail_nxt;
        spm_r       <= spm_nxt;
        lmseq_r     <= lmseq_nxt;
        lmcnt_r     <= lmcnt_nxt;
        act_time_r  <= act_time_nxt;
        err_time_r  <= err_time_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r  <= acc_nxt;
      serr_r <= serr_nxt;
      dup_r  <= dup_nxt;
      miss_r <= miss_nxt;
      fwd_r  <= fwd_nxt;
    end
  end

  // readback follows the registered state, which holds while a result waits
  always_comb begin
    if (rd_sel < 5'(N_COUNTERS)) begin
      readback = 64'(cnt_r[rd_sel[3:0]]);
    end else begin
      unique case (rd_sel)
        RB_LAST_SEQ:   readback = 64'(last_r);
        RB_LEAD_SEQ:   readback = 64'(lead_r);
        RB_TRAIL_SEQ:  readback = 64'(trail_r);
        RB_SPM_SEQ:    readback = 64'(spm_r);
        RB_MISSED_SEQ: readback = 64'(lmseq_r);
        RB_MISSED_CNT: readback = 64'(lmcnt_r);
        RB_ACT_TIME:   readback = act_time_r;
        RB_ERR_TIME:   readback = err_time_r;
        default:       readback = '0;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign accepted    = acc_r;
  assign state_after = state_r;
  assign seq_error   = serr_r;
  assign duplicate   = dup_r;
  assign missed      = 32'(miss_r);
  assign forward_nak = fwd_r;

endmodule

// ----- design/pgm_stream_sequence_tracker.sv -----
// top level of the pgm stream sequence tracker: config registers and wiring
//
// channel  direction  handshake                    contents
// in_*     slave      in_tvalid / in_tready        packet summary, op in in_tuser
// out_*    master     out_tvalid / out_tready      per-packet result and readback
// cfg_*    apb        cfg_psel / cfg_penable       nak_forward_enable, readback_select
//
// one transaction per cycle sustained while the output is not stalled; each item is
// written into the queue and then registered in the back end before its result appears
// the back end updates the session state once per item, one item per cycle unless stalled
// synchronous active-low reset clears the queue, the session state and counters
// a stalled output holds the back end; the queue keeps accepting until full
module pgm_stream_sequence_tracker
  import pst_pkg::*;
#(
  parameter int SEQ_WIDTH   = SEQ_W_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // seq_number[31:0], trail_number[63:32], lead_number[95:64], syn_flag[96],
  // fin_flag[97], rst_flag[98], afi_is_ip[99], extra_naks[105:100],
  // now_time[169:106], zero pad [175:170]
  input  logic [175:0] in_tdata,
  // op[3:0]
  input  logic [3:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // accepted[0], state_after[3:1], seq_error[4], duplicate[5], missed_now[37:6],
  // forward_nak[38], readback_value[102:39], zero pad [103]
  output logic [103:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int   Q_W         = CMD_W + 4 * SEQ_WIDTH + 64;

  logic                 nak_en_r;
  logic [4:0]           rd_sel_r;
  logic                 cfg_wr;

  cmd_t                 f_cmd;
  logic [SEQ_WIDTH-1:0] f_sqn, f_trl, f_led, f_sqm1;
  logic [Q_W-1:0]       q_din;
  logic [Q_W-1:0]       q_dout;
  logic                 q_valid;
  logic                 q_ready;

  cmd_t                 b_cmd;
  logic [SEQ_WIDTH-1:0] b_sqn, b_trl, b_led, b_sqm1;
  logic [63:0]          b_now;

  logic                 r_acc;
  logic [2:0]           r_state;
  logic                 r_serr;
  logic                 r_dup;
  logic [31:0]          r_missed;
  logic                 r_fwd;
  logic [63:0]          r_readback;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nak_en_r <= 1'b0;
      rd_sel_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_NAK_FWD: nak_en_r <= cfg_pwdata[0];
        REG_RD_SEL:  rd_sel_r <= cfg_pwdata[4:0];
        default:     nak_en_r <= nak_en_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_NAK_FWD: cfg_prdata = {31'd0, nak_en_r};
      REG_RD_SEL:  cfg_prdata = {27'd0, rd_sel_r};
      default:     cfg_prdata = '0;
    endcase
  end

  pst_front #(
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_front (
    .op           (in_tuser),
    .seq_number   (in_tdata[31:0]),
    .trail_number (in_tdata[63:32]),
    .lead_number  (in_tdata[95:64]),
    .syn_flag     (in_tdata[96]),
    .fin_flag     (in_tdata[97]),
    .rst_flag     (in_tdata[98]),
    .afi_is_ip    (in_tdata[99]),
    .extra_naks   (in_tdata[105:100]),
    .cmd          (f_cmd),
    .sqn          (f_sqn),
    .trl          (f_trl),
    .led          (f_led),
    .sqm1         (f_sqm1)
  );

  assign q_din = {f_cmd, f_sqn, f_trl, f_led, f_sqm1, in_tdata[169:106]};

  pst_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (q_din),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_dout)
  );

  assign {b_cmd, b_sqn, b_trl, b_led, b_sqm1, b_now} = q_dout;

  pst_back #(
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .cmd         (b_cmd),
    .sqn         (b_sqn),
    .trl         (b_trl),
    .led         (b_led),
    .sqm1        (b_sqm1),
    .now         (b_now),
    .nak_fwd_en  (nak_en_r),
    .rd_sel      (rd_sel_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .accepted    (r_acc),
    .state_after (r_state),
    .seq_error   (r_serr),
    .duplicate   (r_dup),
    .missed      (r_missed),
    .forward_nak (r_fwd),
    .readback    (r_readback)
  );

  assign out_tdata = {1'b0, r_readback, r_fwd, r_missed, r_dup, r_serr, r_state, r_acc};

`ifndef SYNTHESIS
  a_cfg_nak_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_paddr[2] == REG_NAK_FWD |=> nak_en_r == $past(cfg_pwdata[0]))
    else $error("nak forward enable not written");

  a_fwd_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r_fwd |-> r_acc && r_state == ST_SYNC && nak_en_r)
    else $error("forwarded nak without sync state and enable");

  a_dup_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r_dup |-> !r_acc && !r_serr && r_missed == 32'd0)
    else $error("duplicate result also marked accepted or gap");

  a_gap_repair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r_serr |-> r_acc && r_missed != 32'd0)
    else $error("sequence gap without accept or distance");
`endif

endmodule
